### src/wpst_pkg.sv
// Shared types and constants of the window priority slot table.
package wpst_pkg;

	// Width of a stored window id; covers every slot count the table supports.
	localparam int ID_W = 4;

	// Room that a bordered window leaves at the display edges.
	localparam int BORDER_W = 4;
	localparam int BORDER_H = 12;

	// Item kinds.
	localparam logic [1:0] KIND_REQ  = 2'd0;
	localparam logic [1:0] KIND_UP   = 2'd1;
	localparam logic [1:0] KIND_PRIO = 2'd2;
	localparam logic [1:0] KIND_FIND = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_DONE   = 2'd0;
	localparam logic [1:0] STAT_BOUNDS = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] priority_req;
		logic [7:0] left_x;
		logic [7:0] right_x;
		logic [7:0] top_y;
		logic [7:0] bottom_y;
		logic       has_border;
		logic       is_desktop;
		logic [2:0] slot;
		logic [2:0] window_id;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] granted_id;
		logic [2:0] found_slot;
	} result_t;

	typedef struct packed {
		logic [7:0]      win_left;
		logic [7:0]      win_right;
		logic [7:0]      win_top;
		logic [7:0]      win_bottom;
		logic            in_use;
		logic [7:0]      pri;
		logic [ID_W-1:0] ident;
		logic            active;
		logic            bordered;
		logic            desktop;
	} entry_t;

endpackage

### src/wpst_bounds.sv
// Display bounds check for a window request.
module wpst_bounds #(
	parameter int DISPLAY_WIDTH  = 128,
	parameter int DISPLAY_HEIGHT = 64
) (
	input  wpst_pkg::item_t req,
	output logic            bad
);

	localparam logic signed [9:0] LIM_X = 10'(DISPLAY_WIDTH - wpst_pkg::BORDER_W);
	localparam logic signed [9:0] LIM_Y = 10'(DISPLAY_HEIGHT - wpst_pkg::BORDER_H);

	logic signed [9:0] dx;
	logic signed [9:0] dy;
	logic              over_edge;
	logic              too_big;

	// Signed spans: an inverted rectangle passes the size test.
	assign dx = $signed({2'b00, req.right_x}) - $signed({2'b00, req.left_x});
	assign dy = $signed({2'b00, req.bottom_y}) - $signed({2'b00, req.top_y});

	assign over_edge = (req.bottom_y > 8'(DISPLAY_HEIGHT)) || (req.right_x > 8'(DISPLAY_WIDTH));
	assign too_big   = !req.is_desktop && req.has_border && ((dx > LIM_X) || (dy > LIM_Y));
	assign bad       = over_edge || too_big;

endmodule

### src/wpst_table.sv
// Slot table memory: one write port, one registered read port, reset via valid bits.
module wpst_table #(
	parameter int SLOTS = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [$clog2(SLOTS)-1:0] rd_addr,
	output wpst_pkg::entry_t         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(SLOTS)-1:0] wr_addr,
	input  wpst_pkg::entry_t         wr_data
);

	localparam int IW = $clog2(SLOTS);

	wpst_pkg::entry_t mem [SLOTS];
	logic [SLOTS-1:0] valid_q;
	wpst_pkg::entry_t rd_q;
	logic [IW-1:0]    rd_idx_q;
	logic             rd_vld_q;
	wpst_pkg::entry_t blank;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q     <= mem[rd_addr];
		rd_idx_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= valid_q[rd_addr];
		end
	end

	// An unwritten slot reads as cleared, holding its own index as id.
	always_comb begin
		blank       = '0;
		blank.ident = wpst_pkg::ID_W'(rd_idx_q);
		rd_data     = rd_vld_q ? rd_q : blank;
	end

endmodule

### src/window_priority_slot_table.sv
// Top level of the window priority slot table: sequencer around the slot memory.
//
//  channel  | handshake          | payload                 | direction
//  ---------+--------------------+-------------------------+----------
//  command  | start, busy        | item   (wpst_pkg::item_t)  | in
//  result   | done (one cycle)   | result (wpst_pkg::result_t)| out
//
// Flow: a bounds reject or an ignored move-up answers straight from idle; a lookup
// scans the slots in order, one slot read per cycle through the memory port.
// Changing items run a slot search (request and reprioritise only; a request
// writes its slot in the last search cycle), then an update for a move-up
// (ST_MV_A to ST_MV_C) or an absent id (ST_FIX), then an insertion sort (ST_SORT_GO,
// then ST_SORT_KEY and ST_SORT_CMP for each key, ST_SORT_PUT when a key reaches
// slot 0) that compares in ST_SORT_CMP, and then the registered result.
// Reset: arst_n clears the sequencer and the slot valid bits at once.
// Stalls: busy is high until the item finishes; done marks one result for
// exactly one cycle and cannot be held off, and a new item may start then.
module window_priority_slot_table #(
	parameter int SLOTS          = 7,
	parameter int DISPLAY_WIDTH  = 128,
	parameter int DISPLAY_HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  wpst_pkg::item_t   item,
	output logic              busy,
	output logic              done,
	output wpst_pkg::result_t result
);

	localparam int            IW   = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
	localparam logic [IW-1:0] ONE  = IW'(1);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_SCAN     = 4'd1;
	localparam logic [3:0] ST_FIX      = 4'd2;
	localparam logic [3:0] ST_MV_A     = 4'd3;
	localparam logic [3:0] ST_MV_B     = 4'd4;
	localparam logic [3:0] ST_MV_C     = 4'd5;
	localparam logic [3:0] ST_SORT_GO  = 4'd6;
	localparam logic [3:0] ST_SORT_KEY = 4'd7;
	localparam logic [3:0] ST_SORT_CMP = 4'd8;
	localparam logic [3:0] ST_SORT_PUT = 4'd9;

	logic [3:0] state_q, state_d;
	wpst_pkg::item_t   item_q, item_d;
	logic [IW-1:0]     scan_q, scan_d;
	logic [IW-1:0]     k_q, k_d;
	logic [IW-1:0]     j_q, j_d;
	wpst_pkg::entry_t  key_q, key_d;
	wpst_pkg::entry_t  hold_q, hold_d;
	logic [2:0]        gnt_q, gnt_d;
	wpst_pkg::result_t res_q, res_d;
	logic              done_q, done_d;

	logic [IW-1:0]     rd_addr;
	wpst_pkg::entry_t  rd_data;
	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	wpst_pkg::entry_t  wr_data;
	logic              bad;
	logic              match;
	logic              pri_gt;
	logic              sort_last;

	wpst_bounds #(
		.DISPLAY_WIDTH (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT(DISPLAY_HEIGHT)
	) u_bounds (
		.req(item),
		.bad(bad)
	);

	wpst_table #(
		.SLOTS(SLOTS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// Compare logic: free-slot or id match during a scan, priority
	// order during the sort.
	assign match     = (item_q.kind == wpst_pkg::KIND_REQ) ? !rd_data.in_use
		: (rd_data.ident == wpst_pkg::ID_W'(item_q.window_id));
	assign pri_gt    = (rd_data.pri > key_q.pri);
	assign sort_last = (k_q == LAST);

	always_comb begin
		state_d = state_q;
		item_d  = item_q;
		scan_d  = scan_q;
		k_d     = k_q;
		j_d     = j_q;
		key_d   = key_q;
		hold_d  = hold_q;
		gnt_d   = gnt_q;
		res_d   = res_q;
		done_d  = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_d = item;
					gnt_d  = '0;
					scan_d = '0;
					priority if (item.kind == wpst_pkg::KIND_REQ && bad) begin
						done_d = 1'b1;
						res_d  = '{status: wpst_pkg::STAT_BOUNDS, granted_id: '0, found_slot: '0};
					end else if (item.kind == wpst_pkg::KIND_UP) begin
						if (5'(item.slot) >= 5'(SLOTS)) begin
							// Slot beyond the table: ignore, answer done.
							done_d = 1'b1;
							res_d  = '{status: wpst_pkg::STAT_DONE, granted_id: '0, found_slot: '0};
						end else begin
							rd_addr = LAST;
							state_d = ST_MV_A;
						end
					end else begin
						rd_addr = '0;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (match || scan_q == LAST) begin
					unique case (item_q.kind)
						wpst_pkg::KIND_FIND: begin
							done_d  = 1'b1;
							res_d   = '{status: wpst_pkg::STAT_DONE, granted_id: '0,
								found_slot: match ? 3'(scan_q) : 3'd0};
							state_d = ST_IDLE;
						end
						wpst_pkg::KIND_REQ: begin
							if (match) begin
								wr_en              = 1'b1;
								wr_addr            = scan_q;
								wr_data.win_left   = item_q.left_x;
								wr_data.win_right  = item_q.right_x;
								wr_data.win_top    = item_q.top_y;
								wr_data.win_bottom = item_q.bottom_y;
								wr_data.in_use     = 1'b1;
								wr_data.pri        = item_q.priority_req;
								wr_data.active     = 1'b1;
								wr_data.bordered   = item_q.has_border;
								wr_data.desktop    = item_q.is_desktop;
								gnt_d              = rd_data.ident[2:0];
								state_d            = ST_SORT_GO;
							end else begin
								done_d  = 1'b1;
								res_d   = '{status: wpst_pkg::STAT_FULL, granted_id: '0,
									found_slot: '0};
								state_d = ST_IDLE;
							end
						end
						wpst_pkg::KIND_PRIO: begin
							if (match) begin
								wr_en       = 1'b1;
								wr_addr     = scan_q;
								wr_data.pri = item_q.priority_req;
								state_d     = ST_SORT_GO;
							end else begin
								// Absent id: fall back to slot 0.
								rd_addr = '0;
								state_d = ST_FIX;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end else begin
					scan_d  = scan_q + ONE;
					rd_addr = scan_q + ONE;
				end
			end
			ST_FIX: begin
				wr_en       = 1'b1;
				wr_addr     = '0;
				wr_data.pri = item_q.priority_req;
				state_d     = ST_SORT_GO;
			end
			ST_MV_A: begin
				hold_d  = rd_data;
				rd_addr = IW'(item_q.slot);
				state_d = ST_MV_B;
			end
			ST_MV_B: begin
				wr_en          = 1'b1;
				wr_addr        = IW'(item_q.slot);
				wr_data.pri    = hold_q.pri;
				wr_data.active = 1'b1;
				hold_d.pri     = rd_data.pri;
				state_d        = ST_MV_C;
			end
			ST_MV_C: begin
				// Top slot itself: its priority is unchanged and already written.
				if (IW'(item_q.slot) != LAST) begin
					wr_en   = 1'b1;
					wr_addr = LAST;
					wr_data = hold_q;
				end
				state_d = ST_SORT_GO;
			end
			ST_SORT_GO: begin
				k_d     = ONE;
				rd_addr = ONE;
				state_d = ST_SORT_KEY;
			end
			ST_SORT_KEY: begin
				key_d   = rd_data;
				j_d     = k_q - ONE;
				rd_addr = k_q - ONE;
				state_d = ST_SORT_CMP;
			end
			ST_SORT_CMP: begin
				wr_en   = 1'b1;
				wr_addr = j_q + ONE;
				if (pri_gt) begin
					wr_data = rd_data;
					if (j_q == '0) begin
						state_d = ST_SORT_PUT;
					end else begin
						j_d     = j_q - ONE;
						rd_addr = j_q - ONE;
					end
				end else begin
					wr_data = key_q;
					if (sort_last) begin
						done_d  = 1'b1;
						res_d   = '{status: wpst_pkg::STAT_DONE, granted_id: gnt_q, found_slot: '0};
						state_d = ST_IDLE;
					end else begin
						k_d     = k_q + ONE;
						rd_addr = k_q + ONE;
						state_d = ST_SORT_KEY;
					end
				end
			end
			ST_SORT_PUT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = key_q;
				if (sort_last) begin
					done_d  = 1'b1;
					res_d   = '{status: wpst_pkg::STAT_DONE, granted_id: gnt_q, found_slot: '0};
					state_d = ST_IDLE;
				end else begin
					k_d     = k_q + ONE;
					rd_addr = k_q + ONE;
					state_d = ST_SORT_KEY;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// Payload registers: hold the item, counters and result.
	always_ff @(posedge clk) begin
		item_q <= item_d;
		scan_q <= scan_d;
		k_q    <= k_d;
		j_q    <= j_d;
		key_q  <= key_d;
		hold_q <= hold_d;
		gnt_q  <= gnt_d;
		res_q  <= res_d;
	end

`ifndef SYNTHESIS
	// The table is only written while an item is in progress.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !wr_en)
		else $error("slot table written while idle");

	// The sort never takes slot 0 as its key.
	a_sort_key: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT_KEY || state_q == ST_SORT_CMP) |-> (k_q != '0))
		else $error("sort key index is zero");

	// A failed request grants no id and reports no slot.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != wpst_pkg::STAT_DONE)
			|-> (result.granted_id == '0 && result.found_slot == '0))
		else $error("failed request carries an id");

	// A result follows either an accepted item or a finishing sequencer.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without an item");

	// No status code beyond the defined ones.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == wpst_pkg::STAT_DONE
			|| result.status == wpst_pkg::STAT_BOUNDS
			|| result.status == wpst_pkg::STAT_FULL))
		else $error("undefined status code");
`endif

endmodule
